// ----- src/stfe_pkg.sv -----
// Shared types and constants for the scope trigger frame encoder.
// No dependencies; imported by the cfg channel interface and every module.
package stfe_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_SEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LVL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

	// request kinds and run commands
	localparam logic       REQ_SAMPLE = 1'b0;
	localparam logic       REQ_CMD    = 1'b1;
	localparam logic [1:0] RUN_STOP   = 2'd0;
	localparam logic [1:0] RUN_RUN    = 2'd1;
	localparam logic [1:0] RUN_SINGLE = 2'd2;

	// trigger selector
	localparam logic [1:0] TRIG_FREE = 2'd0;
	localparam logic [1:0] TRIG_POS  = 2'd1;
	localparam logic [1:0] TRIG_NEG  = 2'd2;

	// capture phase
	localparam logic [1:0] PH_ARMED   = 2'd0;
	localparam logic [1:0] PH_CAPTURE = 2'd1;
	localparam logic [1:0] PH_DISCARD = 2'd2;

	// second-byte flag patterns and the discard byte
	localparam logic [7:0] FLAG_BURST      = 8'h20;
	localparam logic [7:0] FLAG_BURST_LAST = 8'h40;
	localparam logic [7:0] FLAG_CONT       = 8'h60;
	localparam logic [7:0] FLAG_CONT_END   = 8'hA0;
	localparam logic [7:0] BYTE_DISCARD    = 8'hC0;

	// reset values
	localparam logic [9:0]  TRIG_LVL_RST  = 10'd512;
	localparam logic [8:0]  FRAME_LEN_RST = 9'd480;
	localparam logic [13:0] TIMEOUT_RST   = 14'd10000;
	localparam logic [9:0]  PREV_RST      = 10'd512;

	typedef struct packed {
		logic        cont_mode;
		logic [1:0]  trig_sel;
		logic [9:0]  trig_level;
		logic [8:0]  frame_len;
		logic [13:0] trig_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  run_state;
		logic [1:0]  phase;
		logic [9:0]  prev_sample;
		logic        first_after_arm;
		logic [13:0] wait_count;
		logic [8:0]  rec_count;
	} state_t;

	localparam cfg_t CFG_RST = '{
		cont_mode:    1'b0,
		trig_sel:     TRIG_FREE,
		trig_level:   TRIG_LVL_RST,
		frame_len:    FRAME_LEN_RST,
		trig_timeout: TIMEOUT_RST
	};

	localparam state_t ST_RST = '{
		run_state:       RUN_RUN,
		phase:           PH_ARMED,
		prev_sample:     PREV_RST,
		first_after_arm: 1'b1,
		wait_count:      14'd0,
		rec_count:       9'd0
	};

	// back to waiting for a trigger, counts cleared
	function automatic state_t rearm(state_t s);
		state_t r;
		r                 = s;
		r.phase           = PH_ARMED;
		r.first_after_arm = 1'b1;
		r.wait_count      = '0;
		r.rec_count       = '0;
		return r;
	endfunction

endpackage

// ----- src/stfe_intf.sv -----
// Channel interfaces: request items, encoded bytes, configuration writes.
// Depends on stfe_pkg for the index and data widths.
interface stfe_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [9:0] sample;
	logic [1:0] run_cmd;
	modport source (output valid, req_type, sample, run_cmd, input ready);
	modport sink   (input valid, req_type, sample, run_cmd, output ready);
endinterface

interface stfe_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface

interface stfe_cfg_if import stfe_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/stfe_step.sv -----
// Next-state and byte encoding for one registered request.
// Depends on stfe_pkg (cfg_t, state_t, codes, rearm).
module stfe_step import stfe_pkg::*; #(
	parameter int FRAME_MAX = 480
) (
	input  cfg_t       cfg,
	input  state_t     cur,
	input  logic       req_type,
	input  logic [9:0] sample,
	input  logic [1:0] run_cmd,
	output state_t     nxt,
	output logic [1:0] nres,
	output logic [7:0] byte0,
	output logic [7:0] byte1
);

	localparam logic [8:0] FRAME_MAX_W = 9'(FRAME_MAX);

	logic [8:0]  len;
	logic [7:0]  flag;
	logic [1:0]  ph;
	logic [1:0]  miss_phase;
	logic        go;
	logic        hit;
	logic [9:0]  ref_lvl;
	logic [13:0] wc_inc;
	logic [9:0]  fc_inc;
	logic [8:0]  fc_n;

	always_comb begin
		if (cfg.frame_len == '0) begin
			len = 9'd1;
		end else if (cfg.frame_len > FRAME_MAX_W) begin
			len = FRAME_MAX_W;
		end else begin
			len = cfg.frame_len;
		end
	end

	assign ref_lvl    = cur.first_after_arm ? cfg.trig_level : cur.prev_sample;
	assign wc_inc     = cur.wait_count + 14'd1;
	assign fc_inc     = {1'b0, cur.rec_count} + 10'd1;
	assign miss_phase = cfg.cont_mode ? PH_CAPTURE : PH_DISCARD;

	// crossing sense kept as specified: positive fires falling onto the level
	always_comb begin
		case (cfg.trig_sel)
			TRIG_POS: hit = (ref_lvl > cfg.trig_level) && (sample <= cfg.trig_level);
			TRIG_NEG: hit = (ref_lvl < cfg.trig_level) && (sample >= cfg.trig_level);
			default:  hit = 1'b0;
		endcase
	end

	always_comb begin
		nxt  = cur;
		nres = 2'd0;
		flag = FLAG_BURST;
		ph   = cur.phase;
		go   = 1'b0;
		fc_n = cur.rec_count;
		if (req_type == REQ_CMD) begin
			case (run_cmd)
				RUN_STOP: nxt.run_state = RUN_STOP;
				RUN_RUN: begin
					nxt           = rearm(cur);
					nxt.run_state = RUN_RUN;
				end
				RUN_SINGLE: begin
					nxt           = rearm(cur);
					nxt.run_state = RUN_SINGLE;
					nres          = 2'd1;
				end
				default: ;
			endcase
		end else begin
			go = 1'b1;
			if (cur.phase == PH_ARMED) begin
				if (cfg.trig_sel == TRIG_FREE) begin
					ph = PH_CAPTURE;
				end else if (cfg.trig_timeout == '0) begin
					ph = miss_phase;
				end else begin
					// the trigger or timeout sample is not part of the frame
					go                  = 1'b0;
					nxt.prev_sample     = sample;
					nxt.first_after_arm = 1'b0;
					if (hit) begin
						nxt.wait_count = '0;
						nxt.phase      = PH_CAPTURE;
					end else if (wc_inc >= cfg.trig_timeout) begin
						nxt.wait_count = '0;
						nxt.phase      = miss_phase;
					end else begin
						nxt.wait_count = wc_inc;
					end
				end
			end
			if (go) begin
				nxt.phase = ph;
				if (cfg.cont_mode) begin
					if (cur.run_state != RUN_STOP) begin
						nres = 2'd2;
						if (cur.rec_count >= len) begin
							flag = FLAG_CONT_END;
							fc_n = '0;
							if (cur.run_state == RUN_SINGLE) begin
								nxt.run_state = RUN_STOP;
							end
						end else begin
							flag = FLAG_CONT;
							fc_n = fc_inc[8:0];
						end
					end
					nxt.rec_count = fc_n;
					if (fc_n == '0) begin
						nxt = rearm(nxt);
					end
				end else begin
					if (ph == PH_CAPTURE && cur.run_state != RUN_STOP) begin
						nres = 2'd2;
						flag = (fc_inc >= {1'b0, len}) ? FLAG_BURST_LAST : FLAG_BURST;
					end
					nxt.rec_count = fc_inc[8:0];
					if (fc_inc[8:0] >= len) begin
						if (ph == PH_CAPTURE && cur.run_state == RUN_SINGLE) begin
							nxt.run_state = RUN_STOP;
						end
						nxt = rearm(nxt);
					end
				end
			end
		end
	end

	assign byte0 = {3'b000, sample[9:5]};
	assign byte1 = (nres == 2'd1) ? BYTE_DISCARD : {flag[7:5], sample[4:0]};

endmodule

// ----- src/scope_trigger_frame_encoder.sv -----
// Top level of the scope trigger frame encoder: request register, state,
// config registers and a two-byte output buffer. Depends on stfe_pkg,
// stfe_intf (channels) and stfe_step (per-request logic).
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------
//   req     | in  | valid / ready | req_type, sample[9:0], run_cmd[1:0]
//   rsp     | out | valid / ready | out_byte[7:0], last
//   cfg     | in  | valid / ready | index[2:0], data[13:0] (always ready)
//
// A request is registered, then evaluated when the output buffer is empty
// or drains at that edge; a sample that is sent yields two bytes, so the
// next request waits for the last of them to leave the single byte port.
// Armed or dropped samples and commands go one per cycle unless rsp stalls.
// arst_n clears config to defaults, state to run/armed, and empties buffers.
// A stall on rsp holds the buffer and backs up into req ready.
module scope_trigger_frame_encoder import stfe_pkg::*; #(
	parameter int FRAME_MAX = 480
) (
	input  logic       clk,
	input  logic       arst_n,
	stfe_req_if.sink   req,
	stfe_cfg_if.sink   cfg,
	stfe_rsp_if.source rsp
);

	cfg_t       cfg_q;
	state_t     st_q;
	state_t     st_nxt;

	logic       vld_s1;
	logic       req_type_s1;
	logic [9:0] sample_s1;
	logic [1:0] run_cmd_s1;
	logic       fire_s1;

	logic [1:0] cnt_q;
	logic [7:0] byte0_q;
	logic [7:0] byte1_q;
	logic [1:0] nres;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic       pop;

	assign pop     = rsp.valid && rsp.ready;
	// evaluate only when the buffer is empty after this edge
	assign fire_s1 = vld_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && rsp.ready));
	assign req.ready = !vld_s1 || fire_s1;
	assign cfg.ready = 1'b1;

	assign rsp.valid    = cnt_q != 2'd0;
	assign rsp.out_byte = cnt_q[1] ? byte0_q : byte1_q;
	assign rsp.last     = cnt_q == 2'd1;

	stfe_step #(.FRAME_MAX(FRAME_MAX)) u_step (
		.cfg      (cfg_q),
		.cur      (st_q),
		.req_type (req_type_s1),
		.sample   (sample_s1),
		.run_cmd  (run_cmd_s1),
		.nxt      (st_nxt),
		.nres     (nres),
		.byte0    (byte0),
		.byte1    (byte1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			sample_s1   <= req.sample;
			run_cmd_s1  <= req.run_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (fire_s1) begin
			cnt_q <= nres;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			byte0_q <= byte0;
			byte1_q <= byte1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
			st_q  <= ST_RST;
		end else begin
			// a mode write re-arms on top of whatever the request left
			if (cfg.valid && cfg.index == REG_MODE) begin
				st_q <= rearm(fire_s1 ? st_nxt : st_q);
			end else if (fire_s1) begin
				st_q <= st_nxt;
			end
			if (cfg.valid) begin
				case (cfg.index)
					REG_MODE:      cfg_q.cont_mode    <= cfg.data[0];
					REG_TRIG_SEL:  cfg_q.trig_sel     <= cfg.data[1:0];
					REG_TRIG_LVL:  cfg_q.trig_level   <= cfg.data[9:0];
					REG_FRAME_LEN: cfg_q.frame_len    <= cfg.data[8:0];
					REG_TIMEOUT:   cfg_q.trig_timeout <= cfg.data[13:0];
					default: ;
				endcase
			end
		end
	end

	// single-shot command shows the discard byte as its only byte
	a_single_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && req_type_s1 == REQ_CMD && run_cmd_s1 == RUN_SINGLE)
		|=> (rsp.valid && rsp.last && rsp.out_byte == BYTE_DISCARD))
		else $error("single-shot command did not emit discard byte");

	// a stopped block never sends sample bytes
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && req_type_s1 == REQ_SAMPLE && st_q.run_state == RUN_STOP)
		|=> !rsp.valid)
		else $error("sample bytes sent while stopped");

	// frame counter never runs past FRAME_MAX
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.rec_count <= 9'(FRAME_MAX))
		else $error("frame count beyond FRAME_MAX");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for scope_trigger_frame_encoder: directed table, then random phases.
// Holds its own model of trigger, frame and byte encoding; needs stfe_pkg and stfe_intf.
module tb import stfe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_CAP      = 480;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 175;
	localparam int IDLE_PCT       = 12;
	localparam int MAX_REPORTS    = 10;
	localparam int PREDICT        = -1;

	// codes the block must tolerate but the package leaves unnamed
	localparam logic [1:0] RUN_IGNORED = 2'd3;
	localparam logic [1:0] TRIG_NEVER  = 2'd3;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} enc_byte_t;

	typedef enum {ROW_CFG, ROW_SMP, ROW_CMD} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [9:0]            smp;
		logic [1:0]            cmd;
		int                    n_typed;
		logic [7:0]            b0;
		logic [7:0]            b1;
	} stim_row_t;

	logic clk;
	logic arst_n;

	stfe_req_if req_ch ();
	stfe_rsp_if rsp_ch ();
	stfe_cfg_if cfg_ch ();

	scope_trigger_frame_encoder #(.FRAME_MAX(FRAME_CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	// capture model state
	cfg_t        sim_cfg;
	logic [1:0]  sim_run;
	logic [1:0]  sim_phase;
	logic [9:0]  sim_prev;
	logic        sim_first;
	logic [13:0] sim_wait;
	logic [8:0]  sim_fcount;

	enc_byte_t step_out[$];
	enc_byte_t pending_bytes[$];
	enc_byte_t got_byte;
	enc_byte_t want_byte;
	stim_row_t directed[$];

	int  errors;
	int  quiet;
	bit  steady;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic void rearm_capture();
		sim_phase  = PH_ARMED;
		sim_first  = 1'b1;
		sim_wait   = '0;
		sim_fcount = '0;
	endfunction

	function automatic void push_pair(input logic [9:0] s, input logic [7:0] flag);
		step_out.push_back('{value: {3'b000, s[9:5]}, last: 1'b0});
		step_out.push_back('{value: {3'b000, s[4:0]} | flag, last: 1'b1});
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_MODE: begin
				sim_cfg.cont_mode = val[0];
				rearm_capture();
			end
			REG_TRIG_SEL:  sim_cfg.trig_sel     = val[1:0];
			REG_TRIG_LVL:  sim_cfg.trig_level   = val[9:0];
			REG_FRAME_LEN: sim_cfg.frame_len    = val[8:0];
			REG_TIMEOUT:   sim_cfg.trig_timeout = val[13:0];
			default: ;
		endcase
	endfunction

	// bytes one request should produce; leaves them in step_out
	function automatic void encode_item(input logic rtype, input logic [9:0] s,
			input logic [1:0] c);
		int         len;
		logic [9:0] ref_lvl;
		logic [9:0] lvl;
		logic       hit;
		step_out.delete();
		if (rtype == REQ_CMD) begin
			case (c)
				RUN_STOP: sim_run = RUN_STOP;
				RUN_RUN: begin
					sim_run = RUN_RUN;
					rearm_capture();
				end
				RUN_SINGLE: begin
					sim_run = RUN_SINGLE;
					rearm_capture();
					step_out.push_back('{value: BYTE_DISCARD, last: 1'b1});
				end
				default: ;
			endcase
			return;
		end
		len = int'(sim_cfg.frame_len);
		if (len < 1)
			len = 1;
		if (len > FRAME_CAP)
			len = FRAME_CAP;
		if (sim_phase == PH_ARMED) begin
			if (sim_cfg.trig_sel == TRIG_FREE) begin
				sim_phase = PH_CAPTURE;
			end else if (sim_cfg.trig_timeout == 0) begin
				sim_phase = sim_cfg.cont_mode ? PH_CAPTURE : PH_DISCARD;
			end else begin
				lvl     = sim_cfg.trig_level;
				ref_lvl = sim_first ? lvl : sim_prev;
				// crossing sense as specified: positive fires going down through the level
				hit = (sim_cfg.trig_sel == TRIG_POS && ref_lvl > lvl && s <= lvl) ||
					(sim_cfg.trig_sel == TRIG_NEG && ref_lvl < lvl && s >= lvl);
				sim_prev  = s;
				sim_first = 1'b0;
				if (hit) begin
					sim_wait  = '0;
					sim_phase = PH_CAPTURE;
					return;
				end
				sim_wait = sim_wait + 14'd1;
				if (sim_wait >= sim_cfg.trig_timeout) begin
					sim_wait  = '0;
					sim_phase = sim_cfg.cont_mode ? PH_CAPTURE : PH_DISCARD;
				end
				return;
			end
		end
		if (sim_cfg.cont_mode) begin
			if (sim_run != RUN_STOP) begin
				if (sim_fcount >= len) begin
					push_pair(s, FLAG_CONT_END);
					sim_fcount = '0;
					if (sim_run == RUN_SINGLE)
						sim_run = RUN_STOP;
				end else begin
					push_pair(s, FLAG_CONT);
					sim_fcount = sim_fcount + 9'd1;
				end
			end
			if (sim_fcount == 0)
				rearm_capture();
			return;
		end
		if (sim_phase == PH_CAPTURE && sim_run != RUN_STOP)
			push_pair(s, (sim_fcount + 1 >= len) ? FLAG_BURST_LAST : FLAG_BURST);
		sim_fcount = sim_fcount + 9'd1;
		if (sim_fcount >= len) begin
			if (sim_phase == PH_CAPTURE && sim_run == RUN_SINGLE)
				sim_run = RUN_STOP;
			rearm_capture();
		end
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '{kind: ROW_CFG, idx: idx, val: val, smp: '0, cmd: '0, n_typed: 0,
			b0: '0, b1: '0};
		return r;
	endfunction

	function automatic stim_row_t smp_row(input logic [9:0] s, input int n,
			input logic [7:0] b0, input logic [7:0] b1);
		stim_row_t r;
		r = '{kind: ROW_SMP, idx: '0, val: '0, smp: s, cmd: '0, n_typed: n,
			b0: b0, b1: b1};
		return r;
	endfunction

	function automatic stim_row_t cmd_row(input logic [1:0] c, input int n,
			input logic [7:0] b0);
		stim_row_t r;
		r = '{kind: ROW_CMD, idx: '0, val: '0, smp: '0, cmd: c, n_typed: n,
			b0: b0, b1: '0};
		return r;
	endfunction

	// no requests in flight and no bytes owed
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, val);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_item(input logic rtype, input logic [9:0] s, input logic [1:0] c,
			input int n_typed, input logic [7:0] b0, input logic [7:0] b1);
		int k;
		while (idle_now()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.sample   <= s;
		req_ch.run_cmd  <= c;
		do @(posedge clk); while (!req_ch.ready);
		encode_item(rtype, s, c);
		if (n_typed == PREDICT) begin
			foreach (step_out[k])
				pending_bytes.push_back(step_out[k]);
		end else begin
			for (k = 0; k < n_typed; k++)
				pending_bytes.push_back('{value: (k == 0) ? b0 : b1,
					last: (k == n_typed - 1)});
		end
	endtask

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && !idle_now();
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_byte = '{value: rsp_ch.out_byte, last: rsp_ch.last};
			if (pending_bytes.size() == 0) begin
				note_mismatch($sformatf("unexpected byte %02h last %0b",
					got_byte.value, got_byte.last));
			end else begin
				want_byte = pending_bytes.pop_front();
				if (got_byte.value !== want_byte.value || got_byte.last !== want_byte.last)
					note_mismatch($sformatf("byte %02h last %0b, expected %02h last %0b",
						got_byte.value, got_byte.last, want_byte.value, want_byte.last));
			end
		end
	end

	// nothing moving on any channel for too long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int         p;
		int         i;
		int         r;
		int         v;
		logic       m;
		logic [1:0] sel;
		logic [1:0] c;
		logic [9:0] lvl;
		logic [8:0] len;
		logic [13:0] tmo;
		logic [9:0] s;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_SAMPLE;
		req_ch.sample   = '0;
		req_ch.run_cmd  = RUN_STOP;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_MODE;
		cfg_ch.data     = '0;
		rsp_ch.ready    = 1'b0;
		errors          = 0;
		quiet           = 0;
		steady          = 1'b0;

		sim_cfg  = CFG_RST;
		sim_run  = RUN_RUN;
		sim_prev = PREV_RST;
		rearm_capture();

		// free run burst, reset length: single shot, then length zero acting as one
		directed.push_back(cmd_row(RUN_SINGLE, 1, BYTE_DISCARD));
		directed.push_back(cfg_row(REG_FRAME_LEN, CFG_DATA_W'(0)));
		directed.push_back(smp_row(10'd1023, 2, 8'h1F, 8'h5F));
		directed.push_back(smp_row(10'd0, 0, 8'h00, 8'h00));
		directed.push_back(cmd_row(RUN_RUN, 0, 8'h00));
		directed.push_back(smp_row(10'd0, 2, 8'h00, 8'h40));
		directed.push_back(cmd_row(RUN_STOP, 0, 8'h00));
		directed.push_back(cmd_row(RUN_IGNORED, 0, 8'h00));
		directed.push_back(cmd_row(RUN_RUN, 0, 8'h00));
		// positive trigger, two-sample frame
		directed.push_back(cfg_row(REG_FRAME_LEN, CFG_DATA_W'(2)));
		directed.push_back(cfg_row(REG_TRIG_SEL, CFG_DATA_W'(TRIG_POS)));
		directed.push_back(cfg_row(REG_TIMEOUT, CFG_DATA_W'(3)));
		directed.push_back(smp_row(10'd600, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd512, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd100, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd0, PREDICT, 8'h00, 8'h00));
		// zero timeout opens a thrown-away frame at once
		directed.push_back(cfg_row(REG_FRAME_LEN, CFG_DATA_W'(1)));
		directed.push_back(cfg_row(REG_TIMEOUT, CFG_DATA_W'(0)));
		directed.push_back(smp_row(10'd7, PREDICT, 8'h00, 8'h00));
		// negative trigger at the top level
		directed.push_back(cfg_row(REG_TRIG_SEL, CFG_DATA_W'(TRIG_NEG)));
		directed.push_back(cfg_row(REG_TIMEOUT, CFG_DATA_W'(2)));
		directed.push_back(cfg_row(REG_TRIG_LVL, CFG_DATA_W'(1023)));
		directed.push_back(smp_row(10'd0, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd1023, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd512, PREDICT, 8'h00, 8'h00));
		// selector that never fires always times out
		directed.push_back(cfg_row(REG_TRIG_SEL, CFG_DATA_W'(TRIG_NEVER)));
		directed.push_back(cfg_row(REG_TIMEOUT, CFG_DATA_W'(1)));
		directed.push_back(smp_row(10'd1, PREDICT, 8'h00, 8'h00));
		// continuous stream with end mark, then single shot stop
		directed.push_back(cfg_row(REG_MODE, CFG_DATA_W'(1)));
		directed.push_back(cfg_row(REG_TRIG_SEL, CFG_DATA_W'(TRIG_FREE)));
		directed.push_back(cfg_row(REG_TRIG_LVL, CFG_DATA_W'(0)));
		directed.push_back(smp_row(10'd1023, 2, 8'h1F, 8'h7F));
		directed.push_back(smp_row(10'd682, PREDICT, 8'h00, 8'h00));
		directed.push_back(cmd_row(RUN_SINGLE, 1, BYTE_DISCARD));
		directed.push_back(smp_row(10'd5, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd6, PREDICT, 8'h00, 8'h00));
		directed.push_back(smp_row(10'd7, 0, 8'h00, 8'h00));
		directed.push_back(cmd_row(RUN_RUN, 0, 8'h00));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_CFG: write_reg(directed[i].idx, directed[i].val);
				ROW_SMP: send_item(REQ_SAMPLE, directed[i].smp, 2'($urandom_range(3)),
					directed[i].n_typed, directed[i].b0, directed[i].b1);
				default: send_item(REQ_CMD, 10'($urandom_range(1023)), directed[i].cmd,
					directed[i].n_typed, directed[i].b0, directed[i].b1);
			endcase
		end

		for (p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				m = 1'b0; sel = TRIG_FREE; lvl = 10'd1023; len = 9'd480; tmo = 14'd16383;
			end else if (p == 1) begin
				m = 1'b1; sel = TRIG_POS; lvl = 10'd0; len = 9'd511; tmo = 14'd1;
			end else begin
				m   = 1'($urandom_range(1));
				sel = 2'($urandom_range(3));
				if ($urandom_range(9) == 0)
					lvl = $urandom_range(1) ? 10'd1023 : 10'd0;
				else
					lvl = 10'($urandom_range(1023));
				// short frames keep results flowing; long ones only now and then
				r = $urandom_range(99);
				if (r < 70)      len = 9'($urandom_range(1, 6));
				else if (r < 82) len = 9'($urandom_range(7, 40));
				else if (r < 90) len = 9'd0;
				else if (r < 95) len = 9'(FRAME_CAP);
				else             len = 9'($urandom_range(481, 511));
				r = $urandom_range(99);
				if (r < 75)      tmo = 14'($urandom_range(1, 12));
				else if (r < 88) tmo = 14'd0;
				else if (r < 97) tmo = 14'($urandom_range(13, 300));
				else             tmo = 14'd16383;
			end
			if (p < 2 || $urandom_range(99) < 60) write_reg(REG_MODE, CFG_DATA_W'(m));
			if (p < 2 || $urandom_range(99) < 60) write_reg(REG_TRIG_SEL, CFG_DATA_W'(sel));
			if (p < 2 || $urandom_range(99) < 60) write_reg(REG_TRIG_LVL, CFG_DATA_W'(lvl));
			if (p < 2 || $urandom_range(99) < 60) write_reg(REG_FRAME_LEN, CFG_DATA_W'(len));
			if (p < 2 || $urandom_range(99) < 60) write_reg(REG_TIMEOUT, tmo);
			steady = (p == 2);

			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) begin
					// hold off until the block has caught up
					req_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending_bytes.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(99) < 7) begin
					r = $urandom_range(9);
					if (r < 4)      c = RUN_RUN;
					else if (r < 7) c = RUN_SINGLE;
					else if (r < 9) c = RUN_STOP;
					else            c = RUN_IGNORED;
					send_item(REQ_CMD, 10'($urandom_range(1023)), c, PREDICT, 8'h00, 8'h00);
				end else begin
					// mostly wander around the level so crossings happen often
					if ($urandom_range(99) < 60) begin
						v = int'(sim_cfg.trig_level) + int'($urandom_range(40)) - 20;
						if (v < 0)
							v = 0;
						if (v > 1023)
							v = 1023;
						s = 10'(v);
					end else begin
						s = 10'($urandom_range(1023));
					end
					send_item(REQ_SAMPLE, s, 2'($urandom_range(3)), PREDICT, 8'h00, 8'h00);
				end
			end
		end
		steady = 1'b0;

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
